// ===== rtl/bleadv_pkg.sv =====
// Shared types and constants for the advertisement frame field tagger.
// Used by the parser, the top level and the port checker; no dependencies.
`default_nettype none

package bleadv_pkg;

    // Field sizes of the fixed-length parts of a frame
    localparam logic [7:0] HASH_BYTES        = 8'd3;
    localparam logic [7:0] ENDPOINT_ID_BYTES = 8'd4;
    localparam logic [7:0] MAC_BYTES         = 8'd6;

    // Header byte layout
    localparam logic [7:0] VERSION_MASK  = 8'hE0;
    localparam logic [7:0] PCP_MASK      = 8'h1F;
    localparam int         VERSION_SHIFT = 5;

    // Saturation point of the trailing-byte offset
    localparam logic [7:0] OFFSET_MAX = 8'hFF;

    // Parse phase, also the field kind reported with each byte
    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_HASH    = 4'd1,
        PH_EPID    = 4'd2,
        PH_INFOLEN = 4'd3,
        PH_INFO    = 4'd4,
        PH_MAC     = 4'd5,
        PH_UWBLEN  = 4'd6,
        PH_UWB     = 4'd7,
        PH_EXTRA   = 4'd8,
        PH_TRAIL   = 4'd9
    } phase_t;

    localparam logic [3:0] KIND_MAX = 4'd9;

    // One tagged result
    typedef struct packed {
        logic [7:0] byte_value;
        logic [3:0] field_kind;
        logic [7:0] field_offset;
        logic [2:0] version;
        logic [4:0] pcp;
        logic       frame_end;
        logic       truncated;
        logic       has_uwb;
        logic       has_extra;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/bleadv_parser.sv =====
// Frame phase machine: tags one byte per advance and tracks field state.
// Depends on bleadv_pkg for the phase type, field sizes and result struct.
`default_nettype none

module bleadv_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fast_mode,
    input  wire logic              advance,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output bleadv_pkg::result_t    result
);

    bleadv_pkg::phase_t phase_reg, phase_next;
    logic [7:0] offset_reg, offset_next;
    logic [7:0] length_reg, length_next;
    logic [2:0] version_reg, version_next;
    logic [4:0] pcp_reg, pcp_next;
    logic       uwb_seen_reg, uwb_seen_next;
    logic       extra_seen_reg, extra_seen_next;

    logic [7:0]         offset_inc;
    logic [7:0]         length_dec;
    bleadv_pkg::phase_t after_info;

    assign offset_inc = offset_reg + 8'd1;
    assign length_dec = length_reg - 8'd1;
    assign after_info = fast_mode ? bleadv_pkg::PH_UWBLEN : bleadv_pkg::PH_MAC;

    // Next field state for the byte at hand
    always_comb
    begin
        phase_next      = phase_reg;
        offset_next     = offset_reg;
        length_next     = length_reg;
        version_next    = version_reg;
        pcp_next        = pcp_reg;
        uwb_seen_next   = uwb_seen_reg;
        extra_seen_next = extra_seen_reg;
        case (phase_reg)
            bleadv_pkg::PH_HEADER:
            begin
                version_next = 3'((data_byte & bleadv_pkg::VERSION_MASK)
                                  >> bleadv_pkg::VERSION_SHIFT);
                pcp_next     = 5'(data_byte & bleadv_pkg::PCP_MASK);
                phase_next   = fast_mode ? bleadv_pkg::PH_EPID : bleadv_pkg::PH_HASH;
                offset_next  = 8'd0;
            end
            bleadv_pkg::PH_HASH:
            begin
                offset_next = offset_inc;
                if (offset_inc >= bleadv_pkg::HASH_BYTES)
                begin
                    phase_next  = bleadv_pkg::PH_EPID;
                    offset_next = 8'd0;
                end
            end
            bleadv_pkg::PH_EPID:
            begin
                offset_next = offset_inc;
                if (offset_inc >= bleadv_pkg::ENDPOINT_ID_BYTES)
                begin
                    phase_next  = bleadv_pkg::PH_INFOLEN;
                    offset_next = 8'd0;
                end
            end
            bleadv_pkg::PH_INFOLEN:
            begin
                length_next = data_byte;
                offset_next = 8'd0;
                phase_next  = (data_byte == 8'd0) ? after_info : bleadv_pkg::PH_INFO;
            end
            bleadv_pkg::PH_INFO:
            begin
                length_next = length_dec;
                offset_next = offset_inc;
                if (length_dec == 8'd0)
                begin
                    phase_next  = after_info;
                    offset_next = 8'd0;
                end
            end
            bleadv_pkg::PH_MAC:
            begin
                offset_next = offset_inc;
                if (offset_inc >= bleadv_pkg::MAC_BYTES)
                begin
                    phase_next  = bleadv_pkg::PH_UWBLEN;
                    offset_next = 8'd0;
                end
            end
            bleadv_pkg::PH_UWBLEN:
            begin
                uwb_seen_next = 1'b1;
                length_next   = data_byte;
                offset_next   = 8'd0;
                phase_next    = (data_byte == 8'd0) ? bleadv_pkg::PH_EXTRA
                                                    : bleadv_pkg::PH_UWB;
            end
            bleadv_pkg::PH_UWB:
            begin
                length_next = length_dec;
                offset_next = offset_inc;
                if (length_dec == 8'd0)
                begin
                    phase_next  = bleadv_pkg::PH_EXTRA;
                    offset_next = 8'd0;
                end
            end
            bleadv_pkg::PH_EXTRA:
            begin
                extra_seen_next = 1'b1;
                phase_next      = bleadv_pkg::PH_TRAIL;
                offset_next     = 8'd0;
            end
            default:
            begin
                // Trailing bytes: saturate the offset
                phase_next = bleadv_pkg::PH_TRAIL;
                if (offset_reg != bleadv_pkg::OFFSET_MAX)
                    offset_next = offset_inc;
            end
        endcase
    end

    // Tag the byte; frame status only on the last byte
    always_comb
    begin
        result.byte_value   = data_byte;
        result.field_kind   = phase_reg;
        result.field_offset = offset_reg;
        result.version      = version_next;
        result.pcp          = pcp_next;
        result.frame_end    = last_byte;
        result.truncated    = last_byte && (phase_next inside {
                                  bleadv_pkg::PH_HASH, bleadv_pkg::PH_EPID,
                                  bleadv_pkg::PH_INFOLEN, bleadv_pkg::PH_INFO,
                                  bleadv_pkg::PH_MAC, bleadv_pkg::PH_UWB});
        result.has_uwb      = last_byte && uwb_seen_next;
        result.has_extra    = last_byte && extra_seen_next;
    end

    // Advance state on each transfer; rearm at frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bleadv_pkg::PH_HEADER;
            offset_reg     <= 8'd0;
            length_reg     <= 8'd0;
            version_reg    <= 3'd0;
            pcp_reg        <= 5'd0;
            uwb_seen_reg   <= 1'b0;
            extra_seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                phase_reg      <= bleadv_pkg::PH_HEADER;
                offset_reg     <= 8'd0;
                length_reg     <= 8'd0;
                version_reg    <= 3'd0;
                pcp_reg        <= 5'd0;
                uwb_seen_reg   <= 1'b0;
                extra_seen_reg <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                offset_reg     <= offset_next;
                length_reg     <= length_next;
                version_reg    <= version_next;
                pcp_reg        <= pcp_next;
                uwb_seen_reg   <= uwb_seen_next;
                extra_seen_reg <= extra_seen_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ble_connection_advert_parser_top.sv =====
// m_tvalid rises once a byte has passed the input register and then the result register.
// Throughput: one byte per cycle; while a result waits for m_tready the input
// register takes one more byte, then s_tready drops.
// Reset (rst_n, asynchronous, active low) empties both registers, sets the
// parser to expect a header byte and clears fast_mode.
// Depends on bleadv_pkg and bleadv_parser.
`default_nettype none

module ble_connection_advert_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,     // fast_mode
    // Byte input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] data_byte
    input  wire logic        s_tlast,       // last_byte
    // Tagged result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [7:0] byte_value, [15:8] field_offset,
                                            // [18:16] version, [23:19] pcp,
                                            // [24] truncated, [25] has_uwb,
                                            // [26] has_extra, [31:27] zero
    output logic [3:0]       m_tuser,       // [3:0] field_kind
    output logic             m_tlast        // frame_end
);

    logic                fast_mode_reg;
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    bleadv_pkg::result_t out_res_reg;
    bleadv_pkg::result_t res;
    logic                advance;

    // Move the held byte into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Hold the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fast_mode_reg <= 1'b0;
        else if (cfg_we)
            fast_mode_reg <= cfg_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    bleadv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fast_mode (fast_mode_reg),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    // Pack the result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_res_reg.has_extra,
                       out_res_reg.has_uwb,
                       out_res_reg.truncated,
                       out_res_reg.pcp,
                       out_res_reg.version,
                       out_res_reg.field_offset,
                       out_res_reg.byte_value};
    assign m_tuser  = out_res_reg.field_kind;
    assign m_tlast  = out_res_reg.frame_end;

endmodule

`default_nettype wire

// ===== rtl/bleadv_checker.sv =====
// Port-level checks on the tagged result stream, bound to the top level.
// Depends on bleadv_pkg and ble_connection_advert_parser_top.
`default_nettype none

module bleadv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [3:0]  m_tuser,
    input wire logic        m_tlast
);

    // A stalled result transfer holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Frame status flags appear only on the last byte of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[26:24] == 3'd0)
        else $error("frame status outside frame end");

    // An extra byte can only follow a UWB length byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[26] |-> m_tdata[25])
        else $error("extra reported without UWB");

    // Field kind stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= bleadv_pkg::KIND_MAX)
        else $error("field kind out of range");

    // The header is a single byte at offset zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == bleadv_pkg::PH_HEADER |-> m_tdata[15:8] == 8'd0)
        else $error("header byte with nonzero offset");

endmodule

bind ble_connection_advert_parser_top bleadv_checker u_bleadv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
